### hdl/smc_pkg.sv
// shared types and constants of the soil moisture conditioner
`timescale 1ns / 1ps

package smc_pkg;

   localparam int FRAC_BITS    = 8;
   localparam int HUM_BITS     = 15;
   localparam int CSR_IDX_BITS = 2;

   localparam logic [HUM_BITS-1:0] OLD_WEIGHT = 15'd179;
   localparam logic [HUM_BITS-1:0] NEW_WEIGHT = 15'd77;
   localparam logic [HUM_BITS-1:0] FULL_SCALE = 15'd25600;

   localparam logic [15:0] DRY_RESET   = 16'd4094;
   localparam logic [15:0] WET_RESET   = 16'd1740;
   localparam logic [15:0] FLOOR_RESET = 16'd100;

   localparam logic [CSR_IDX_BITS-1:0] CSR_DRY_POINT   = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WET_POINT   = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_NOISE_FLOOR = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_TRIM,
      ST_DIV_MEAN,
      ST_LAG_OLD,
      ST_LAG_NEW,
      ST_LEVEL,
      ST_HUM_MUL,
      ST_HUM_DIV,
      ST_OUT
   } smc_state_type;

endpackage

### hdl/smc_req_if.sv
// sample input channel
`timescale 1ns / 1ps

interface smc_req_if #(
   parameter int SAMPLE_BITS = 12
);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

### hdl/smc_rsp_if.sv
// result output channel
`timescale 1ns / 1ps

interface smc_rsp_if #(
   parameter int SAMPLE_BITS = 12
);
   import smc_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [HUM_BITS-1:0]    humidity;
   logic [SAMPLE_BITS-1:0] filtered_level;
   logic [SAMPLE_BITS-1:0] window_mean;

   modport source (output valid, output humidity, output filtered_level,
                   output window_mean, input ready);
   modport sink   (input valid, input humidity, input filtered_level,
                   input window_mean, output ready);
endinterface

### hdl/smc_csr_if.sv
// register write channel
`timescale 1ns / 1ps

interface smc_csr_if #(
   parameter int SAMPLE_BITS = 12
);
   import smc_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [CSR_IDX_BITS-1:0] index;
   logic [SAMPLE_BITS-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### hdl/soil_moisture_conditioner.sv
// soil moisture conditioner: trimmed window mean, lag filter, humidity mapping
//
// channel    dir  payload                                  handshake
// req_chan   in   sample                                   valid/ready
// rsp_chan   out  humidity, filtered_level, window_mean    valid/ready
// csr_chan   in   index, data                              valid/ready, always ready
//
// a sample that does not close a window is stored and the block stays idle
// the closing sample runs a scan over the window, a reciprocal multiply for the mean,
// the lag filter and level steps, a humidity multiply, then a bit-serial division
// reset clears fill count, filter state and the output valid flag, loads the calibration defaults
// a result waiting on rsp_chan does not block input; the next result stalls until it is taken
`timescale 1ns / 1ps

module soil_moisture_conditioner #(
   parameter int WINDOW_SIZE = 6,
   parameter int SAMPLE_BITS = 12
) (
   input  logic      clock,
   input  logic      reset,
   smc_req_if.sink   req_chan,
   smc_rsp_if.source rsp_chan,
   smc_csr_if.sink   csr_chan
);
   import smc_pkg::*;

   localparam int SB   = SAMPLE_BITS;
   localparam int IDXW = $clog2(WINDOW_SIZE);
   localparam int SUMW = SB + $clog2(WINDOW_SIZE);
   localparam int LAGW = SB + FRAC_BITS;
   localparam int NUMW = SB + HUM_BITS;
   localparam int ACCW = LAGW + HUM_BITS;
   localparam int CNTW = $clog2(NUMW);

   localparam int     TRIM_N  = WINDOW_SIZE - 2;
   localparam int     RSH     = SUMW + $clog2(TRIM_N);
   localparam int     RCPW    = SUMW + 1;
   localparam int     TPW     = SUMW + RCPW;
   localparam longint RCP_VAL = ((longint'(1) << RSH) + longint'(TRIM_N) - 1) /
                                longint'(TRIM_N);

   localparam logic [IDXW-1:0] LAST_IDX = IDXW'(WINDOW_SIZE - 1);
   localparam logic [CNTW-1:0] LAST_CNT = CNTW'(NUMW - 1);
   localparam logic [RCPW-1:0] TRIM_RCP = RCPW'(RCP_VAL);

   smc_state_type state_ff, state_in;

   logic [SB-1:0]   window_ff [WINDOW_SIZE];
   logic [IDXW-1:0] fill_ff, fill_in;
   logic [IDXW-1:0] idx_ff, idx_in;
   logic [SUMW-1:0] sum_ff, sum_in;
   logic [SB-1:0]   lo_ff, lo_in;
   logic [SB-1:0]   hi_ff, hi_in;
   logic [SB-1:0]   div_rem_ff, div_rem_in;
   logic [NUMW-1:0] div_quo_ff, div_quo_in;
   logic [CNTW-1:0] div_cnt_ff, div_cnt_in;
   logic [ACCW-1:0] acc_ff, acc_in;
   logic [LAGW-1:0] lag_ff, lag_in;
   logic [SB-1:0]   mean_ff, mean_in;
   logic [SB-1:0]   level_ff, level_in;
   logic [SB-1:0]   diff_mag_ff, diff_mag_in;
   logic [SB-1:0]   span_mag_ff, span_mag_in;
   logic            hum_zero_ff, hum_zero_in;
   logic [SB-1:0]   dry_ff, wet_ff, floor_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [HUM_BITS-1:0] rsp_hum_ff, rsp_hum_in;
   logic [SB-1:0]       rsp_level_ff, rsp_level_in;
   logic [SB-1:0]       rsp_mean_ff, rsp_mean_in;

   logic            req_fire;
   logic            out_free;
   logic [SB-1:0]   win_rd;
   logic [TPW-1:0]  trim_prod;
   logic [SB-1:0]   divisor;
   logic [SB:0]     rem_sh, rem_diff;
   logic            rem_ge;
   logic [LAGW-1:0] mul_a;
   logic [HUM_BITS-1:0] mul_b;
   logic [ACCW-1:0] product;
   logic [ACCW-1:0] lag_sum;
   logic [SB-1:0]   mean_src;
   logic [LAGW-1:0] fresh;
   logic [SB-1:0]   level_raw, level_nf;
   logic [SB:0]     diff_s, span_s;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.humidity       = rsp_hum_ff;
   assign rsp_chan.filtered_level = rsp_level_ff;
   assign rsp_chan.window_mean    = rsp_mean_ff;

   // window read for the scan
   assign win_rd = window_ff[idx_ff];

   // trimmed sum times the reciprocal of the trimmed window size
   assign trim_prod = TPW'(div_quo_ff[SUMW-1:0]) * TPW'(TRIM_RCP);

   // restoring divider step for the humidity division
   assign divisor  = span_mag_ff;
   assign rem_sh   = {div_rem_ff, div_quo_ff[NUMW-1]};
   assign rem_diff = rem_sh - {1'b0, divisor};
   assign rem_ge   = !rem_diff[SB];

   // shared multiplier
   assign mean_src = (state_ff == ST_LAG_OLD) ? div_quo_ff[SB-1:0] : mean_ff;
   assign fresh    = {mean_src, {FRAC_BITS{1'b0}}};
   assign product  = ACCW'(mul_a) * ACCW'(mul_b);
   assign lag_sum  = acc_ff + product;

   always_comb begin
      mul_a = fresh;
      mul_b = NEW_WEIGHT;
      unique case (state_ff)
         ST_LAG_OLD: begin
            mul_a = (lag_ff == '0) ? fresh : lag_ff;
            mul_b = OLD_WEIGHT;
         end
         ST_HUM_MUL: begin
            mul_a = LAGW'(diff_mag_ff);
            mul_b = FULL_SCALE;
         end
         default: begin
            mul_a = fresh;
            mul_b = NEW_WEIGHT;
         end
      endcase
   end

   // level after noise floor and signed distances from the dry point
   assign level_raw = lag_ff[LAGW-1:FRAC_BITS];
   assign level_nf  = (level_raw < floor_ff) ? '0 : level_raw;
   assign diff_s    = {1'b0, dry_ff} - {1'b0, level_nf};
   assign span_s    = {1'b0, dry_ff} - {1'b0, wet_ff};

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      idx_in       = idx_ff;
      sum_in       = sum_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      div_rem_in   = div_rem_ff;
      div_quo_in   = div_quo_ff;
      div_cnt_in   = div_cnt_ff;
      acc_in       = acc_ff;
      lag_in       = lag_ff;
      mean_in      = mean_ff;
      level_in     = level_ff;
      diff_mag_in  = diff_mag_ff;
      span_mag_in  = span_mag_ff;
      hum_zero_in  = hum_zero_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_hum_in   = rsp_hum_ff;
      rsp_level_in = rsp_level_ff;
      rsp_mean_in  = rsp_mean_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (fill_ff == LAST_IDX) begin
                  fill_in  = '0;
                  idx_in   = '0;
                  state_in = ST_SCAN;
               end else begin
                  fill_in = fill_ff + 1'b1;
               end
            end
         end
         ST_SCAN: begin
            if (idx_ff == '0) begin
               sum_in = SUMW'(win_rd);
               lo_in  = win_rd;
               hi_in  = win_rd;
            end else begin
               sum_in = sum_ff + SUMW'(win_rd);
               if (win_rd < lo_ff) lo_in = win_rd;
               if (win_rd > hi_ff) hi_in = win_rd;
            end
            if (idx_ff == LAST_IDX) begin
               state_in = ST_TRIM;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_TRIM: begin
            div_quo_in = NUMW'(sum_ff - SUMW'(lo_ff) - SUMW'(hi_ff));
            div_rem_in = '0;
            div_cnt_in = '0;
            state_in   = ST_DIV_MEAN;
         end
         ST_DIV_MEAN: begin
            div_quo_in = NUMW'(trim_prod[RSH+SB-1:RSH]);
            state_in   = ST_LAG_OLD;
         end
         ST_HUM_DIV: begin
            div_rem_in = rem_ge ? rem_diff[SB-1:0] : rem_sh[SB-1:0];
            div_quo_in = {div_quo_ff[NUMW-2:0], rem_ge};
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_cnt_ff == LAST_CNT) begin
               state_in = ST_OUT;
            end
         end
         ST_LAG_OLD: begin
            mean_in  = div_quo_ff[SB-1:0];
            acc_in   = product;
            state_in = ST_LAG_NEW;
         end
         ST_LAG_NEW: begin
            lag_in   = lag_sum[LAGW+FRAC_BITS-1:FRAC_BITS];
            state_in = ST_LEVEL;
         end
         ST_LEVEL: begin
            level_in    = level_nf;
            diff_mag_in = diff_s[SB] ? SB'(-diff_s) : diff_s[SB-1:0];
            span_mag_in = span_s[SB] ? SB'(-span_s) : span_s[SB-1:0];
            hum_zero_in = (span_s == '0) ||
                          ((diff_s != '0) && (diff_s[SB] != span_s[SB]));
            state_in    = ST_HUM_MUL;
         end
         ST_HUM_MUL: begin
            div_quo_in = product[NUMW-1:0];
            div_rem_in = '0;
            div_cnt_in = '0;
            state_in   = ST_HUM_DIV;
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (hum_zero_ff) begin
                  rsp_hum_in = '0;
               end else if (div_quo_ff > NUMW'(FULL_SCALE)) begin
                  rsp_hum_in = FULL_SCALE;
               end else begin
                  rsp_hum_in = div_quo_ff[HUM_BITS-1:0];
               end
               rsp_level_in = level_ff;
               rsp_mean_in  = mean_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         lag_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         dry_ff       <= SB'(DRY_RESET);
         wet_ff       <= SB'(WET_RESET);
         floor_ff     <= SB'(FLOOR_RESET);
      end else begin
         fill_ff      <= fill_in;
         lag_ff       <= lag_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_chan.valid && csr_chan.ready) begin
            unique case (csr_chan.index)
               CSR_DRY_POINT:   dry_ff   <= csr_chan.data;
               CSR_WET_POINT:   wet_ff   <= csr_chan.data;
               CSR_NOISE_FLOOR: floor_ff <= csr_chan.data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         window_ff[fill_ff] <= req_chan.sample;
      end
      idx_ff       <= idx_in;
      sum_ff       <= sum_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      div_rem_ff   <= div_rem_in;
      div_quo_ff   <= div_quo_in;
      div_cnt_ff   <= div_cnt_in;
      acc_ff       <= acc_in;
      mean_ff      <= mean_in;
      level_ff     <= level_in;
      diff_mag_ff  <= diff_mag_in;
      span_mag_ff  <= span_mag_in;
      hum_zero_ff  <= hum_zero_in;
      rsp_hum_ff   <= rsp_hum_in;
      rsp_level_ff <= rsp_level_in;
      rsp_mean_ff  <= rsp_mean_in;
   end

endmodule
